// File: hw/rtl/ers_pkg.sv
package ers_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int START_TRACK = 40;
  localparam int TAG_W       = 8;
  localparam int TRACK_W     = 10;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_CHECK,
    ST_REMOVE
  } ers_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;       // capture the incoming transaction
    logic do_add;        // store request at tail, post add result
    logic finish_empty;  // serve on empty queue, post null result
    logic scan_init;     // clear best candidate, scan index to 0
    logic scan_step;     // compare one entry, advance index
    logic flip;          // reverse sweep direction
    logic pick_head;     // FIFO policy: oldest entry is the pick
    logic remove;        // drop picked entry, post served result
  } ers_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_serve;
    logic empty;
    logic elevator;
    logic scan_last;
    logic found;
  } ers_stat_t;

endpackage

// File: hw/rtl/ers_ctrl.sv
module ers_ctrl import ers_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ers_stat_t stat,
  output ers_cmd_t  cmd,
  output logic      busy
);

  ers_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat.op_serve || stat.empty) state_nxt = ST_IDLE;
        else if (!stat.elevator)          state_nxt = ST_REMOVE;
        else                              state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = stat.found ? ST_REMOVE : ST_SCAN;
      end
      ST_REMOVE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.load_in = start;
      end
      ST_EXEC: begin
        if (!stat.op_serve)     cmd.do_add       = 1'b1;
        else if (stat.empty)    cmd.finish_empty = 1'b1;
        else if (!stat.elevator) cmd.pick_head   = 1'b1;
        else                    cmd.scan_init    = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_CHECK: begin
        if (!stat.found) begin
          cmd.flip      = 1'b1;
          cmd.scan_init = 1'b1;
        end
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // an entry is only dropped after a pick was made
  a_remove_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> stat.found)
    else $error("remove without a picked entry");

  // no new transaction while one is in flight
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |-> (state_r == ST_IDLE))
    else $error("transaction captured while busy");

endmodule

// File: hw/rtl/ers_dpath.sv
module ers_dpath import ers_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ers_cmd_t           cmd,
  output ers_stat_t          stat,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_operation,
  input  logic [TAG_W-1:0]   in_request_tag,
  input  logic [TRACK_W-1:0] in_request_track,
  output logic               out_valid,
  output logic               out_served_valid,
  output logic [TAG_W-1:0]   out_served_tag,
  output logic [TRACK_W-1:0] out_served_track,
  output logic               out_add_accepted,
  output logic               out_sweep_up,
  output logic               out_queue_empty
);

  // queue storage, oldest at index 0
  logic [TRACK_W-1:0] track_q_r [QUEUE_DEPTH];
  logic [TAG_W-1:0]   tag_q_r   [QUEUE_DEPTH];

  logic [CNT_W-1:0]   count_r;
  logic [TRACK_W-1:0] head_r;
  logic               dir_r;
  logic               policy_r;

  logic               op_r;
  logic [TAG_W-1:0]   in_tag_r;
  logic [TRACK_W-1:0] in_track_r;

  logic [IDX_W-1:0]   scan_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [TRACK_W-1:0] best_track_r;
  logic [TAG_W-1:0]   best_tag_r;

  logic               res_strobe_r;
  logic               res_valid_r;
  logic [TAG_W-1:0]   res_tag_r;
  logic [TRACK_W-1:0] res_track_r;
  logic               res_accepted_r;
  logic               res_empty_r;

  logic [TRACK_W-1:0] cur_track;
  logic [TAG_W-1:0]   cur_tag;
  logic               cand;
  logic               add_ok;

  assign cur_track = track_q_r[scan_idx_r];
  assign cur_tag   = tag_q_r[scan_idx_r];
  assign add_ok    = (count_r < CNT_W'(QUEUE_DEPTH));

  // strict compares keep the oldest entry on equal tracks
  always_comb begin
    if (dir_r) begin
      cand = (cur_track >= head_r) && (!found_r || (cur_track < best_track_r));
    end else begin
      cand = (cur_track <= head_r) && (!found_r || (cur_track > best_track_r));
    end
  end

  assign stat.op_serve  = (op_r == OP_SERVE);
  assign stat.empty     = (count_r == '0);
  assign stat.elevator  = policy_r;
  assign stat.scan_last = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);
  assign stat.found     = found_r;

  // queue storage: tail write on add, shift-down past the pick on remove
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.do_add && add_ok && (CNT_W'(i) == count_r)) begin
        track_q_r[i] <= in_track_r;
        tag_q_r[i]   <= in_tag_r;
      end else if (cmd.remove && (IDX_W'(i) >= best_idx_r) && (i < QUEUE_DEPTH - 1)) begin
        track_q_r[i] <= track_q_r[(i + 1) % QUEUE_DEPTH];
        tag_q_r[i]   <= tag_q_r[(i + 1) % QUEUE_DEPTH];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      head_r       <= TRACK_W'(START_TRACK);
      dir_r        <= 1'b0;
      policy_r     <= 1'b1;
      res_strobe_r <= 1'b0;
    end else begin
      if (cfg_wr_en) policy_r <= cfg_wr_data;
      if (cmd.do_add && add_ok) count_r <= count_r + CNT_W'(1);
      if (cmd.remove) begin
        count_r <= count_r - CNT_W'(1);
        if (policy_r) head_r <= best_track_r;
      end
      if (cmd.flip) dir_r <= ~dir_r;
      res_strobe_r <= cmd.do_add | cmd.finish_empty | cmd.remove;
    end
  end

  // transaction capture, scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r       <= in_operation;
      in_tag_r   <= in_request_tag;
      in_track_r <= in_request_track;
    end

    if (cmd.scan_init) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      if (cand) begin
        found_r      <= 1'b1;
        best_idx_r   <= scan_idx_r;
        best_track_r <= cur_track;
        best_tag_r   <= cur_tag;
      end
    end else if (cmd.pick_head) begin
      found_r      <= 1'b1;
      best_idx_r   <= '0;
      best_track_r <= track_q_r[0];
      best_tag_r   <= tag_q_r[0];
    end

    if (cmd.do_add) begin
      res_valid_r    <= 1'b0;
      res_tag_r      <= '0;
      res_track_r    <= '0;
      res_accepted_r <= add_ok;
      res_empty_r    <= !add_ok && (count_r == '0);
    end else if (cmd.finish_empty) begin
      res_valid_r    <= 1'b0;
      res_tag_r      <= '0;
      res_track_r    <= '0;
      res_accepted_r <= 1'b0;
      res_empty_r    <= 1'b1;
    end else if (cmd.remove) begin
      res_valid_r    <= 1'b1;
      res_tag_r      <= best_tag_r;
      res_track_r    <= best_track_r;
      res_accepted_r <= 1'b0;
      res_empty_r    <= (count_r == CNT_W'(1));
    end
  end

  assign out_valid        = res_strobe_r;
  assign out_served_valid = res_valid_r;
  assign out_served_tag   = res_tag_r;
  assign out_served_track = res_track_r;
  assign out_add_accepted = res_accepted_r;
  assign out_sweep_up     = dir_r;
  assign out_queue_empty  = res_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("remove did not drop exactly one entry");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    res_strobe_r |=> !res_strobe_r)
    else $error("back-to-back result strobes");

endmodule

// File: hw/rtl/elevator_request_scheduler_core.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------------
// input     | start & !busy      | in_operation, in_request_tag, in_request_track
// result    | out_valid (1 cyc)  | out_served_valid/tag/track, out_add_accepted,
//           |                    | out_sweep_up, out_queue_empty
// config    | cfg_wr_en          | cfg_wr_data (policy_elevator)
//
// One transaction at a time. An add or a serve on an empty queue ends in EXEC;
// a FIFO serve picks the head in EXEC and drops it in REMOVE; an elevator serve
// scans in SCAN, tests in CHECK, flips the sweep and rescans if none was found,
// then drops the pick in REMOVE. The single entry comparator visits one queue
// slot per cycle; the result strobe is registered from the ending state.
// Sync active-low reset: empty queue, head at START_TRACK, sweeping down,
// elevator policy. The result strobe cannot be stalled; busy drops in the
// strobe cycle, so a new transaction may be taken at the edge that ends it.
module elevator_request_scheduler_core import ers_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [TAG_W-1:0]   in_request_tag,
  input  logic [TRACK_W-1:0] in_request_track,
  // result channel
  output logic               out_valid,
  output logic               out_served_valid,
  output logic [TAG_W-1:0]   out_served_tag,
  output logic [TRACK_W-1:0] out_served_track,
  output logic               out_add_accepted,
  output logic               out_sweep_up,
  output logic               out_queue_empty,
  // policy register
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  ers_cmd_t  cmd;
  ers_stat_t stat;

  // sequencer: capture, scan passes, direction flip, removal
  ers_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // queue, head/direction state, comparator and result registers
  ers_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_operation     (in_operation),
    .in_request_tag   (in_request_tag),
    .in_request_track (in_request_track),
    .out_valid        (out_valid),
    .out_served_valid (out_served_valid),
    .out_served_tag   (out_served_tag),
    .out_served_track (out_served_track),
    .out_add_accepted (out_add_accepted),
    .out_sweep_up     (out_sweep_up),
    .out_queue_empty  (out_queue_empty)
  );

endmodule
